// File: sv/a64d_pkg.sv
// Shared types and codes for the A64 subset decoder.
package a64d_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned OP_W   = 6;
	localparam int unsigned IMM_W  = 28;

	// Operation codes reported on the output
	typedef enum logic [OP_W-1:0] {
		OP_UNKNOWN  = 6'd0,
		OP_NOP      = 6'd1,
		OP_BR       = 6'd2,
		OP_BLR      = 6'd3,
		OP_RET      = 6'd4,
		OP_MOVN     = 6'd5,
		OP_MOVZ     = 6'd6,
		OP_MOVK     = 6'd7,
		OP_ADD_IMM  = 6'd8,
		OP_SUB_IMM  = 6'd9,
		OP_SUBS_IMM = 6'd10,
		OP_SBFM     = 6'd11,
		OP_UBFM     = 6'd12,
		OP_MOV      = 6'd13,
		OP_ORR_REG  = 6'd14,
		OP_AND_REG  = 6'd15,
		OP_EOR_REG  = 6'd16,
		OP_ADD_REG  = 6'd17,
		OP_SUB_REG  = 6'd18,
		OP_SUBS_REG = 6'd19,
		OP_MADD     = 6'd20,
		OP_MSUB     = 6'd21,
		OP_UDIV     = 6'd22,
		OP_SDIV     = 6'd23,
		OP_LSLV     = 6'd24,
		OP_LSRV     = 6'd25,
		OP_ASRV     = 6'd26,
		OP_CSEL     = 6'd27,
		OP_CSINC    = 6'd28,
		OP_STR_IMM  = 6'd29,
		OP_LDR_IMM  = 6'd30,
		OP_LDP      = 6'd31,
		OP_STP      = 6'd32,
		OP_CBZ      = 6'd33,
		OP_CBNZ     = 6'd34,
		OP_BCOND    = 6'd35,
		OP_B        = 6'd36,
		OP_BL       = 6'd37
	} op_t;

	// Encoding groups, found in priority order
	typedef enum logic [4:0] {
		GRP_NONE,
		GRP_NOP,
		GRP_BR,
		GRP_BLR,
		GRP_RET,
		GRP_MOVW,
		GRP_ADDSUB_IMM,
		GRP_BITFIELD,
		GRP_LOGIC_REG,
		GRP_ADDSUB_REG,
		GRP_MADD,
		GRP_DPROC2,
		GRP_CSEL,
		GRP_LDST_IMM,
		GRP_LDST_PAIR,
		GRP_CMP_BR,
		GRP_BCOND,
		GRP_B,
		GRP_BL
	} grp_t;

	// Fixed encodings
	localparam logic [WORD_W-1:0] NOP_WORD  = 32'hD503201F;
	localparam logic [WORD_W-1:0] RBR_MASK  = 32'hFFFFFC1F;
	localparam logic [WORD_W-1:0] BR_WORD   = 32'hD61F0000;
	localparam logic [WORD_W-1:0] BLR_WORD  = 32'hD63F0000;
	localparam logic [WORD_W-1:0] RET_WORD  = 32'hD65F0000;
	localparam logic [5:0] MOVW_KEY     = 6'h25;
	localparam logic [5:0] ADDSUB_KEY   = 6'h22;
	localparam logic [5:0] BITFIELD_KEY = 6'h26;
	localparam logic [4:0] LOGIC_KEY    = 5'h0A;
	localparam logic [4:0] ADDSUB_R_KEY = 5'h0B;
	localparam logic [4:0] MADD_KEY     = 5'h1B;
	localparam logic [7:0] DPROC2_KEY   = 8'hD6;
	localparam logic [7:0] CSEL_KEY     = 8'hD4;
	localparam logic [5:0] CMP_BR_KEY   = 6'h1A;
	localparam logic [7:0] BCOND_KEY    = 8'h54;
	localparam logic [5:0] B_KEY        = 6'h05;
	localparam logic [5:0] BL_KEY       = 6'h25;

	// Divide and variable shift opcodes, bits 15:10
	localparam logic [5:0] DP_UDIV = 6'h02;
	localparam logic [5:0] DP_SDIV = 6'h03;
	localparam logic [5:0] DP_LSLV = 6'h08;
	localparam logic [5:0] DP_LSRV = 6'h09;
	localparam logic [5:0] DP_ASRV = 6'h0A;

	// Decoded record
	typedef struct packed {
		op_t                     op_kind;
		logic                    is_wide;
		logic [4:0]              dest_reg;
		logic [4:0]              first_src_reg;
		logic [4:0]              second_src_reg;
		logic [4:0]              third_reg;
		logic signed [IMM_W-1:0] imm_value;
		logic [1:0]              half_select;
		logic [3:0]              cond_code;
		logic [5:0]              rotate_imm;
		logic [5:0]              size_imm;
	} dec_t;

endpackage

// File: sv/a64d_instr_if.sv
// Instruction word channel.
interface a64d_instr_if;
	logic        valid;
	logic        ready;
	logic [31:0] instr_word;

	modport source (output valid, output instr_word, input ready);
	modport sink (input valid, input instr_word, output ready);
endinterface

// File: sv/a64d_dec_if.sv
// Decoded record channel.
interface a64d_dec_if;
	logic               valid;
	logic               ready;
	logic [5:0]         op_kind;
	logic               is_wide;
	logic [4:0]         dest_reg;
	logic [4:0]         first_src_reg;
	logic [4:0]         second_src_reg;
	logic [4:0]         third_reg;
	logic signed [27:0] imm_value;
	logic [1:0]         half_select;
	logic [3:0]         cond_code;
	logic [5:0]         rotate_imm;
	logic [5:0]         size_imm;

	modport source (output valid, output op_kind, output is_wide, output dest_reg,
		output first_src_reg, output second_src_reg, output third_reg,
		output imm_value, output half_select, output cond_code,
		output rotate_imm, output size_imm, input ready);
	modport sink (input valid, input op_kind, input is_wide, input dest_reg,
		input first_src_reg, input second_src_reg, input third_reg,
		input imm_value, input half_select, input cond_code,
		input rotate_imm, input size_imm, output ready);
endinterface

// File: sv/a64d_classify.sv
// Priority group match of an instruction word.
module a64d_classify (
	input  logic [31:0]     word,
	output a64d_pkg::grp_t  grp
);

	// First matching group wins
	always_comb begin
		if (word == a64d_pkg::NOP_WORD) begin
			grp = a64d_pkg::GRP_NOP;
		end else if ((word & a64d_pkg::RBR_MASK) == a64d_pkg::BR_WORD) begin
			grp = a64d_pkg::GRP_BR;
		end else if ((word & a64d_pkg::RBR_MASK) == a64d_pkg::BLR_WORD) begin
			grp = a64d_pkg::GRP_BLR;
		end else if ((word & a64d_pkg::RBR_MASK) == a64d_pkg::RET_WORD) begin
			grp = a64d_pkg::GRP_RET;
		end else if (word[28:23] == a64d_pkg::MOVW_KEY) begin
			grp = a64d_pkg::GRP_MOVW;
		end else if (word[28:23] == a64d_pkg::ADDSUB_KEY) begin
			grp = a64d_pkg::GRP_ADDSUB_IMM;
		end else if (word[28:23] == a64d_pkg::BITFIELD_KEY) begin
			grp = a64d_pkg::GRP_BITFIELD;
		end else if (word[28:24] == a64d_pkg::LOGIC_KEY) begin
			grp = a64d_pkg::GRP_LOGIC_REG;
		end else if (word[28:24] == a64d_pkg::ADDSUB_R_KEY) begin
			grp = a64d_pkg::GRP_ADDSUB_REG;
		end else if (word[28:24] == a64d_pkg::MADD_KEY && word[30:29] == 2'b00) begin
			grp = a64d_pkg::GRP_MADD;
		end else if (word[28:21] == a64d_pkg::DPROC2_KEY) begin
			grp = a64d_pkg::GRP_DPROC2;
		end else if (word[28:21] == a64d_pkg::CSEL_KEY) begin
			grp = a64d_pkg::GRP_CSEL;
		end else if (word[29:27] == 3'd7 && !word[26] && word[25:24] == 2'd1) begin
			grp = a64d_pkg::GRP_LDST_IMM;
		end else if (word[29:27] == 3'd5 && !word[26]) begin
			grp = a64d_pkg::GRP_LDST_PAIR;
		end else if (word[30:25] == a64d_pkg::CMP_BR_KEY) begin
			grp = a64d_pkg::GRP_CMP_BR;
		end else if (word[31:24] == a64d_pkg::BCOND_KEY) begin
			grp = a64d_pkg::GRP_BCOND;
		end else if (word[31:26] == a64d_pkg::B_KEY) begin
			grp = a64d_pkg::GRP_B;
		end else if (word[31:26] == a64d_pkg::BL_KEY) begin
			grp = a64d_pkg::GRP_BL;
		end else begin
			grp = a64d_pkg::GRP_NONE;
		end
	end

endmodule

// File: sv/a64d_fields.sv
// Operation, immediate and condition build for a matched group.
module a64d_fields (
	input  logic [31:0]     word,
	input  a64d_pkg::grp_t  grp,
	output a64d_pkg::dec_t  rec
);

	logic [27:0] imm19_x4;
	logic [27:0] imm26_x4;

	assign imm19_x4 = {{7{word[23]}}, word[23:5], 2'b00};
	assign imm26_x4 = {word[25:0], 2'b00};

	// Raw fields pass for every group; op, immediate and condition by group
	always_comb begin
		rec                = '0;
		rec.op_kind        = a64d_pkg::OP_UNKNOWN;
		rec.is_wide        = word[31];
		rec.dest_reg       = word[4:0];
		rec.first_src_reg  = word[9:5];
		rec.second_src_reg = word[20:16];
		rec.third_reg      = word[14:10];
		rec.half_select    = word[22:21];
		rec.rotate_imm     = word[21:16];
		rec.size_imm       = word[15:10];
		rec.imm_value      = '0;
		rec.cond_code      = '0;
		case (grp)
			a64d_pkg::GRP_NOP: rec.op_kind = a64d_pkg::OP_NOP;
			a64d_pkg::GRP_BR:  rec.op_kind = a64d_pkg::OP_BR;
			a64d_pkg::GRP_BLR: rec.op_kind = a64d_pkg::OP_BLR;
			a64d_pkg::GRP_RET: rec.op_kind = a64d_pkg::OP_RET;
			a64d_pkg::GRP_MOVW: begin
				rec.imm_value = {12'd0, word[20:5]};
				if (word[30:29] == 2'd0) begin
					rec.op_kind = a64d_pkg::OP_MOVN;
				end else if (word[30:29] == 2'd2) begin
					rec.op_kind = a64d_pkg::OP_MOVZ;
				end else begin
					rec.op_kind = a64d_pkg::OP_MOVK;
				end
			end
			a64d_pkg::GRP_ADDSUB_IMM: begin
				rec.imm_value = word[22] ? {4'd0, word[21:10], 12'd0}
					: {16'd0, word[21:10]};
				if (word[29]) begin
					rec.op_kind = a64d_pkg::OP_SUBS_IMM;
				end else begin
					rec.op_kind = word[30] ? a64d_pkg::OP_SUB_IMM : a64d_pkg::OP_ADD_IMM;
				end
			end
			a64d_pkg::GRP_BITFIELD: begin
				rec.op_kind = (word[30:29] == 2'd0) ? a64d_pkg::OP_SBFM : a64d_pkg::OP_UBFM;
			end
			a64d_pkg::GRP_LOGIC_REG: begin
				if (word[30:29] == 2'd1 && !word[21]) begin
					rec.op_kind = (word[9:5] == 5'd31) ? a64d_pkg::OP_MOV
						: a64d_pkg::OP_ORR_REG;
				end else if (word[30:29] == 2'd0) begin
					rec.op_kind = a64d_pkg::OP_AND_REG;
				end else if (word[30:29] == 2'd2) begin
					rec.op_kind = a64d_pkg::OP_EOR_REG;
				end else begin
					rec.op_kind = a64d_pkg::OP_ORR_REG;
				end
			end
			a64d_pkg::GRP_ADDSUB_REG: begin
				if (word[29]) begin
					rec.op_kind = a64d_pkg::OP_SUBS_REG;
				end else begin
					rec.op_kind = word[30] ? a64d_pkg::OP_SUB_REG : a64d_pkg::OP_ADD_REG;
				end
			end
			a64d_pkg::GRP_MADD: begin
				rec.op_kind = word[15] ? a64d_pkg::OP_MSUB : a64d_pkg::OP_MADD;
			end
			a64d_pkg::GRP_DPROC2: begin
				case (word[15:10])
					a64d_pkg::DP_UDIV: rec.op_kind = a64d_pkg::OP_UDIV;
					a64d_pkg::DP_SDIV: rec.op_kind = a64d_pkg::OP_SDIV;
					a64d_pkg::DP_LSLV: rec.op_kind = a64d_pkg::OP_LSLV;
					a64d_pkg::DP_LSRV: rec.op_kind = a64d_pkg::OP_LSRV;
					a64d_pkg::DP_ASRV: rec.op_kind = a64d_pkg::OP_ASRV;
					default:           rec.op_kind = a64d_pkg::OP_UNKNOWN;
				endcase
			end
			a64d_pkg::GRP_CSEL: begin
				rec.cond_code = word[15:12];
				rec.op_kind   = (word[11:10] == 2'd1) ? a64d_pkg::OP_CSINC : a64d_pkg::OP_CSEL;
			end
			a64d_pkg::GRP_LDST_IMM: begin
				rec.is_wide   = (word[31:30] == 2'd3);
				rec.imm_value = (word[31:30] == 2'd3) ? {13'd0, word[21:10], 3'd0}
					: {14'd0, word[21:10], 2'd0};
				rec.op_kind   = (word[23:22] == 2'd0) ? a64d_pkg::OP_STR_IMM
					: a64d_pkg::OP_LDR_IMM;
			end
			a64d_pkg::GRP_LDST_PAIR: begin
				rec.is_wide   = (word[31:30] == 2'd2);
				rec.imm_value = (word[31:30] == 2'd2) ? {{18{word[21]}}, word[21:15], 3'd0}
					: {{19{word[21]}}, word[21:15], 2'd0};
				rec.op_kind   = word[22] ? a64d_pkg::OP_LDP : a64d_pkg::OP_STP;
			end
			a64d_pkg::GRP_CMP_BR: begin
				rec.imm_value = imm19_x4;
				rec.op_kind   = word[24] ? a64d_pkg::OP_CBNZ : a64d_pkg::OP_CBZ;
			end
			a64d_pkg::GRP_BCOND: begin
				rec.imm_value = imm19_x4;
				rec.cond_code = word[3:0];
				rec.op_kind   = a64d_pkg::OP_BCOND;
			end
			a64d_pkg::GRP_B: begin
				rec.imm_value = imm26_x4;
				rec.op_kind   = a64d_pkg::OP_B;
			end
			a64d_pkg::GRP_BL: begin
				rec.imm_value = imm26_x4;
				rec.op_kind   = a64d_pkg::OP_BL;
			end
			default: rec.op_kind = a64d_pkg::OP_UNKNOWN;
		endcase
	end

endmodule

// File: sv/arm64_subset_instruction_decoder.sv
// Throughput: one word per cycle; each stage holds while the stage after it is full and cannot move.
// Stages: input register, group match, record build into the output register.
// Reset clears the stage valid bits at once; the output is empty after reset.
// No state carries from one word to the next.
module arm64_subset_instruction_decoder (
	input  logic      clk,
	input  logic      arst_n,
	a64d_instr_if.sink  instr,
	a64d_dec_if.source  dec
);

	logic                 v_s1, v_s2, v_s3;
	logic                 rdy_s1, rdy_s2, rdy_s3;
	logic [31:0]          word_s1, word_s2;
	a64d_pkg::grp_t       grp_s2;
	a64d_pkg::grp_t       grp_c;
	a64d_pkg::dec_t       rec_c;
	a64d_pkg::dec_t       rec_s3;

	// Stage moves when empty or when the next stage moves
	assign rdy_s3      = !v_s3 || dec.ready;
	assign rdy_s2      = !v_s2 || rdy_s3;
	assign rdy_s1      = !v_s1 || rdy_s2;
	assign instr.ready = rdy_s1;

	a64d_classify u_classify (
		.word (word_s1),
		.grp  (grp_c)
	);

	a64d_fields u_fields (
		.word (word_s2),
		.grp  (grp_s2),
		.rec  (rec_c)
	);

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= instr.valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (rdy_s1 && instr.valid) begin
			word_s1 <= instr.instr_word;
		end
		if (rdy_s2 && v_s1) begin
			word_s2 <= word_s1;
			grp_s2  <= grp_c;
		end
		if (rdy_s3 && v_s2) begin
			rec_s3 <= rec_c;
		end
	end

	// Drive the output word
	assign dec.valid          = v_s3;
	assign dec.op_kind        = rec_s3.op_kind;
	assign dec.is_wide        = rec_s3.is_wide;
	assign dec.dest_reg       = rec_s3.dest_reg;
	assign dec.first_src_reg  = rec_s3.first_src_reg;
	assign dec.second_src_reg = rec_s3.second_src_reg;
	assign dec.third_reg      = rec_s3.third_reg;
	assign dec.imm_value      = rec_s3.imm_value;
	assign dec.half_select    = rec_s3.half_select;
	assign dec.cond_code      = rec_s3.cond_code;
	assign dec.rotate_imm     = rec_s3.rotate_imm;
	assign dec.size_imm       = rec_s3.size_imm;

`ifndef NO_ASSERTIONS
	a_unknown_clean: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && rec_s3.op_kind == a64d_pkg::OP_UNKNOWN
		|-> rec_s3.imm_value == '0 && rec_s3.cond_code == '0)
		else $error("unknown word carries immediate or condition");

	a_cond_owner: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && rec_s3.cond_code != '0
		|-> rec_s3.op_kind == a64d_pkg::OP_CSEL || rec_s3.op_kind == a64d_pkg::OP_CSINC
			|| rec_s3.op_kind == a64d_pkg::OP_BCOND)
		else $error("condition set on a non-conditional operation");

	a_stage_advance: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && rdy_s3 |=> v_s3)
		else $error("word lost between match and output stage");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !dec.ready |=> v_s3 && $stable(rec_s3))
		else $error("output record changed under stall");
`endif

endmodule

// File: dv/arm64_subset_instruction_decoder_tb.sv
// Self-checking testbench for the A64 subset instruction decoder.
`timescale 1ns / 100ps

module arm64_subset_instruction_decoder_tb;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 10;
	localparam int PHASE_WORDS    = 425;
	localparam int MAX_REPORTS    = 10;

	logic clk;
	logic arst_n;

	a64d_instr_if instr_ch ();
	a64d_dec_if   dec_ch ();

	arm64_subset_instruction_decoder i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.instr  (instr_ch),
		.dec    (dec_ch)
	);

	logic [31:0]     words_to_send[$];
	a64d_pkg::dec_t  pending_decodes[$];
	a64d_pkg::dec_t  want_rec;

	int src_idle_pct;
	int snk_stall_pct;
	int mismatch_cnt;
	int words_sent;
	int decodes_checked;
	int idle_cycles;
	int op_seen[int'(a64d_pkg::OP_BL) + 1];

	// Free-running clock, 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Expected decode of one instruction word, first matching group wins
	function automatic a64d_pkg::dec_t decode_word(input logic [31:0] w);
		a64d_pkg::dec_t d;
		d                = '0;
		d.op_kind        = a64d_pkg::OP_UNKNOWN;
		d.is_wide        = w[31];
		d.dest_reg       = w[4:0];
		d.first_src_reg  = w[9:5];
		d.second_src_reg = w[20:16];
		d.third_reg      = w[14:10];
		d.half_select    = w[22:21];
		d.rotate_imm     = w[21:16];
		d.size_imm       = w[15:10];
		if (w == a64d_pkg::NOP_WORD) begin
			d.op_kind = a64d_pkg::OP_NOP;
		end else if ((w & a64d_pkg::RBR_MASK) == a64d_pkg::BR_WORD) begin
			d.op_kind = a64d_pkg::OP_BR;
		end else if ((w & a64d_pkg::RBR_MASK) == a64d_pkg::BLR_WORD) begin
			d.op_kind = a64d_pkg::OP_BLR;
		end else if ((w & a64d_pkg::RBR_MASK) == a64d_pkg::RET_WORD) begin
			d.op_kind = a64d_pkg::OP_RET;
		end else if (w[28:23] == a64d_pkg::MOVW_KEY) begin
			d.imm_value = {12'd0, w[20:5]};
			case (w[30:29])
				2'd0: d.op_kind = a64d_pkg::OP_MOVN;
				2'd2: d.op_kind = a64d_pkg::OP_MOVZ;
				default: d.op_kind = a64d_pkg::OP_MOVK;
			endcase
		end else if (w[28:23] == a64d_pkg::ADDSUB_KEY) begin
			d.imm_value = w[22] ? {4'd0, w[21:10], 12'd0} : {16'd0, w[21:10]};
			// any flag-setting form reports as SUBS
			if (w[29])
				d.op_kind = a64d_pkg::OP_SUBS_IMM;
			else
				d.op_kind = w[30] ? a64d_pkg::OP_SUB_IMM : a64d_pkg::OP_ADD_IMM;
		end else if (w[28:23] == a64d_pkg::BITFIELD_KEY) begin
			d.op_kind = (w[30:29] == 2'd0) ? a64d_pkg::OP_SBFM : a64d_pkg::OP_UBFM;
		end else if (w[28:24] == a64d_pkg::LOGIC_KEY) begin
			if (w[30:29] == 2'd1 && !w[21])
				d.op_kind = (w[9:5] == 5'd31) ? a64d_pkg::OP_MOV : a64d_pkg::OP_ORR_REG;
			else if (w[30:29] == 2'd0)
				d.op_kind = a64d_pkg::OP_AND_REG;
			else if (w[30:29] == 2'd2)
				d.op_kind = a64d_pkg::OP_EOR_REG;
			else
				d.op_kind = a64d_pkg::OP_ORR_REG;
		end else if (w[28:24] == a64d_pkg::ADDSUB_R_KEY) begin
			if (w[29])
				d.op_kind = a64d_pkg::OP_SUBS_REG;
			else
				d.op_kind = w[30] ? a64d_pkg::OP_SUB_REG : a64d_pkg::OP_ADD_REG;
		end else if (w[28:24] == a64d_pkg::MADD_KEY && w[30:29] == 2'd0) begin
			d.op_kind = w[15] ? a64d_pkg::OP_MSUB : a64d_pkg::OP_MADD;
		end else if (w[28:21] == a64d_pkg::DPROC2_KEY) begin
			case (w[15:10])
				a64d_pkg::DP_UDIV: d.op_kind = a64d_pkg::OP_UDIV;
				a64d_pkg::DP_SDIV: d.op_kind = a64d_pkg::OP_SDIV;
				a64d_pkg::DP_LSLV: d.op_kind = a64d_pkg::OP_LSLV;
				a64d_pkg::DP_LSRV: d.op_kind = a64d_pkg::OP_LSRV;
				a64d_pkg::DP_ASRV: d.op_kind = a64d_pkg::OP_ASRV;
				default: d.op_kind = a64d_pkg::OP_UNKNOWN;
			endcase
		end else if (w[28:21] == a64d_pkg::CSEL_KEY) begin
			d.cond_code = w[15:12];
			d.op_kind   = (w[11:10] == 2'd1) ? a64d_pkg::OP_CSINC : a64d_pkg::OP_CSEL;
		end else if (w[29:27] == 3'b111 && !w[26] && w[25:24] == 2'b01) begin
			// load/store unsigned offset: width from size, scale by 8 or 4
			d.is_wide   = (w[31:30] == 2'd3);
			d.imm_value = d.is_wide ? {13'd0, w[21:10], 3'd0} : {14'd0, w[21:10], 2'd0};
			d.op_kind   = (w[23:22] == 2'd0) ? a64d_pkg::OP_STR_IMM : a64d_pkg::OP_LDR_IMM;
		end else if (w[29:27] == 3'b101 && !w[26]) begin
			d.is_wide   = (w[31:30] == 2'd2);
			d.imm_value = d.is_wide ? {{18{w[21]}}, w[21:15], 3'd0}
				: {{19{w[21]}}, w[21:15], 2'd0};
			d.op_kind   = w[22] ? a64d_pkg::OP_LDP : a64d_pkg::OP_STP;
		end else if (w[30:25] == a64d_pkg::CMP_BR_KEY) begin
			d.imm_value = {{7{w[23]}}, w[23:5], 2'd0};
			d.op_kind   = w[24] ? a64d_pkg::OP_CBNZ : a64d_pkg::OP_CBZ;
		end else if (w[31:24] == a64d_pkg::BCOND_KEY) begin
			d.cond_code = w[3:0];
			d.imm_value = {{7{w[23]}}, w[23:5], 2'd0};
			d.op_kind   = a64d_pkg::OP_BCOND;
		end else if (w[31:26] == a64d_pkg::B_KEY) begin
			d.imm_value = {w[25:0], 2'd0};
			d.op_kind   = a64d_pkg::OP_B;
		end else if (w[31:26] == a64d_pkg::BL_KEY) begin
			d.imm_value = {w[25:0], 2'd0};
			d.op_kind   = a64d_pkg::OP_BL;
		end
		return d;
	endfunction

	// Random word aimed at one operation's encoding
	function automatic logic [31:0] make_word(input a64d_pkg::op_t op);
		logic [31:0] w;
		w = $urandom;
		case (op)
			a64d_pkg::OP_NOP: w = a64d_pkg::NOP_WORD;
			a64d_pkg::OP_BR:  w = a64d_pkg::BR_WORD | {22'd0, w[9:5], 5'd0};
			a64d_pkg::OP_BLR: w = a64d_pkg::BLR_WORD | {22'd0, w[9:5], 5'd0};
			a64d_pkg::OP_RET: w = a64d_pkg::RET_WORD | {22'd0, w[9:5], 5'd0};
			a64d_pkg::OP_MOVN: begin
				w[28:23] = a64d_pkg::MOVW_KEY;
				w[30:29] = 2'd0;
			end
			a64d_pkg::OP_MOVZ: begin
				w[28:23] = a64d_pkg::MOVW_KEY;
				w[30:29] = 2'd2;
			end
			a64d_pkg::OP_MOVK: begin
				w[28:23] = a64d_pkg::MOVW_KEY;
				w[29]    = 1'b1;
			end
			a64d_pkg::OP_ADD_IMM, a64d_pkg::OP_SUB_IMM: begin
				w[28:23] = a64d_pkg::ADDSUB_KEY;
				w[29]    = 1'b0;
				w[30]    = (op == a64d_pkg::OP_SUB_IMM);
			end
			a64d_pkg::OP_SUBS_IMM: begin
				w[28:23] = a64d_pkg::ADDSUB_KEY;
				w[29]    = 1'b1;
			end
			a64d_pkg::OP_SBFM: begin
				w[28:23] = a64d_pkg::BITFIELD_KEY;
				w[30:29] = 2'd0;
			end
			a64d_pkg::OP_UBFM: begin
				w[28:23] = a64d_pkg::BITFIELD_KEY;
				if (w[30:29] == 2'd0)
					w[29] = 1'b1;
			end
			a64d_pkg::OP_MOV, a64d_pkg::OP_ORR_REG: begin
				w[28:24] = a64d_pkg::LOGIC_KEY;
				w[30:29] = 2'd1;
				w[21]    = 1'b0;
				if (op == a64d_pkg::OP_MOV)
					w[9:5] = 5'd31;
				else if (w[0])
					w[30:29] = 2'd3;
			end
			a64d_pkg::OP_AND_REG, a64d_pkg::OP_EOR_REG: begin
				w[28:24] = a64d_pkg::LOGIC_KEY;
				w[30:29] = (op == a64d_pkg::OP_AND_REG) ? 2'd0 : 2'd2;
			end
			a64d_pkg::OP_ADD_REG, a64d_pkg::OP_SUB_REG: begin
				w[28:24] = a64d_pkg::ADDSUB_R_KEY;
				w[29]    = 1'b0;
				w[30]    = (op == a64d_pkg::OP_SUB_REG);
			end
			a64d_pkg::OP_SUBS_REG: begin
				w[28:24] = a64d_pkg::ADDSUB_R_KEY;
				w[29]    = 1'b1;
			end
			a64d_pkg::OP_MADD, a64d_pkg::OP_MSUB: begin
				w[28:24] = a64d_pkg::MADD_KEY;
				w[30:29] = 2'd0;
				w[15]    = (op == a64d_pkg::OP_MSUB);
			end
			a64d_pkg::OP_UDIV, a64d_pkg::OP_SDIV, a64d_pkg::OP_LSLV, a64d_pkg::OP_LSRV,
					a64d_pkg::OP_ASRV: begin
				w[28:21] = a64d_pkg::DPROC2_KEY;
				case (op)
					a64d_pkg::OP_UDIV: w[15:10] = a64d_pkg::DP_UDIV;
					a64d_pkg::OP_SDIV: w[15:10] = a64d_pkg::DP_SDIV;
					a64d_pkg::OP_LSLV: w[15:10] = a64d_pkg::DP_LSLV;
					a64d_pkg::OP_LSRV: w[15:10] = a64d_pkg::DP_LSRV;
					default: w[15:10] = a64d_pkg::DP_ASRV;
				endcase
			end
			a64d_pkg::OP_CSEL, a64d_pkg::OP_CSINC: begin
				w[28:21] = a64d_pkg::CSEL_KEY;
				if (op == a64d_pkg::OP_CSINC)
					w[11:10] = 2'd1;
				else if (w[11:10] == 2'd1)
					w[11] = 1'b1;
			end
			a64d_pkg::OP_STR_IMM, a64d_pkg::OP_LDR_IMM: begin
				w[29:27] = 3'b111;
				w[26]    = 1'b0;
				w[25:24] = 2'b01;
				if (op == a64d_pkg::OP_STR_IMM)
					w[23:22] = 2'd0;
				else if (w[23:22] == 2'd0)
					w[22] = 1'b1;
			end
			a64d_pkg::OP_LDP, a64d_pkg::OP_STP: begin
				// keep bit 25 low so the word stays out of the register groups
				w[29:27] = 3'b101;
				w[26]    = 1'b0;
				w[25]    = 1'b0;
				w[22]    = (op == a64d_pkg::OP_LDP);
			end
			a64d_pkg::OP_CBZ, a64d_pkg::OP_CBNZ: begin
				w[30:25] = a64d_pkg::CMP_BR_KEY;
				w[24]    = (op == a64d_pkg::OP_CBNZ);
			end
			a64d_pkg::OP_BCOND: w[31:24] = a64d_pkg::BCOND_KEY;
			a64d_pkg::OP_B:     w[31:26] = a64d_pkg::B_KEY;
			a64d_pkg::OP_BL:    w[31:26] = a64d_pkg::BL_KEY;
			default: begin
				// divide/shift group with an opcode outside the list
				w[28:21] = a64d_pkg::DPROC2_KEY;
				if (w[15:10] == a64d_pkg::DP_UDIV || w[15:10] == a64d_pkg::DP_SDIV
						|| w[15:10] == a64d_pkg::DP_LSLV
						|| w[15:10] == a64d_pkg::DP_LSRV
						|| w[15:10] == a64d_pkg::DP_ASRV)
					w[15] = 1'b1;
			end
		endcase
		return w;
	endfunction

	// Compare one field, report the first few misses
	task automatic check_field(input string fname, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatch_cnt++;
			if (mismatch_cnt <= MAX_REPORTS)
				$display("mismatch on decode %0d, %s: expected %h, got %h",
					decodes_checked, fname, want, got);
		end
	endtask

	// Drive instruction words: advance when the current word is taken
	always @(posedge clk) begin
		if (!arst_n) begin
			instr_ch.valid <= 1'b0;
		end else if (!instr_ch.valid || instr_ch.ready) begin
			if (words_to_send.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				instr_ch.valid      <= 1'b1;
				instr_ch.instr_word <= words_to_send.pop_front();
			end else begin
				instr_ch.valid <= 1'b0;
			end
		end
	end

	// Stall the decoded record channel at random
	always @(posedge clk) begin
		if (!arst_n)
			dec_ch.ready <= 1'b0;
		else
			dec_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
	end

	// Check each decoded word, then record new expectations; watch for hangs
	always @(posedge clk) begin
		if (arst_n) begin
			if (dec_ch.valid && dec_ch.ready) begin
				if (pending_decodes.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= MAX_REPORTS)
						$display("decoded word with nothing expected, op_kind %0d",
							dec_ch.op_kind);
				end else begin
					want_rec = pending_decodes.pop_front();
					check_field("op_kind", want_rec.op_kind, dec_ch.op_kind);
					check_field("is_wide", want_rec.is_wide, dec_ch.is_wide);
					check_field("dest_reg", want_rec.dest_reg, dec_ch.dest_reg);
					check_field("first_src_reg", want_rec.first_src_reg,
						dec_ch.first_src_reg);
					check_field("second_src_reg", want_rec.second_src_reg,
						dec_ch.second_src_reg);
					check_field("third_reg", want_rec.third_reg, dec_ch.third_reg);
					check_field("imm_value", want_rec.imm_value, dec_ch.imm_value);
					check_field("half_select", want_rec.half_select, dec_ch.half_select);
					check_field("cond_code", want_rec.cond_code, dec_ch.cond_code);
					check_field("rotate_imm", want_rec.rotate_imm, dec_ch.rotate_imm);
					check_field("size_imm", want_rec.size_imm, dec_ch.size_imm);
					decodes_checked++;
				end
			end
			if (instr_ch.valid && instr_ch.ready) begin
				want_rec = decode_word(instr_ch.instr_word);
				pending_decodes.push_back(want_rec);
				op_seen[want_rec.op_kind]++;
				words_sent++;
			end
			if ((instr_ch.valid && instr_ch.ready) || (dec_ch.valid && dec_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles, %0d decodes outstanding",
					idle_cycles, pending_decodes.size());
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Reset, directed words, then random phases with different idling
	initial begin
		int   src_pct[4];
		int   snk_pct[4];
		int   mix;
		int   flip_bit;
		int   ops_hit;
		logic [31:0] w;

		src_pct = '{0, 70, 0, 33};
		snk_pct = '{0, 0, 70, 33};
		clk                 = 1'b0;
		arst_n              = 1'b0;
		instr_ch.valid      = 1'b0;
		instr_ch.instr_word = '0;
		dec_ch.ready        = 1'b0;
		src_idle_pct        = 0;
		snk_stall_pct       = 0;
		mismatch_cnt        = 0;
		words_sent          = 0;
		decodes_checked     = 0;
		idle_cycles         = 0;
		ops_hit             = 0;
		foreach (op_seen[k])
			op_seen[k] = 0;

		// Directed: field extremes, one word per operation, near misses
		words_to_send.push_back(32'h0000_0000);
		words_to_send.push_back(32'hFFFF_FFFF);
		words_to_send.push_back(a64d_pkg::NOP_WORD ^ 32'h1);
		words_to_send.push_back(a64d_pkg::RET_WORD | 32'h0000_03C0);
		words_to_send.push_back(32'hD2FF_FFE0);
		words_to_send.push_back(32'h917F_FFFF);
		words_to_send.push_back(32'hF97F_FFFF);
		words_to_send.push_back(32'hA960_0000);
		words_to_send.push_back(32'h291F_8000);
		words_to_send.push_back(32'hB580_0000);
		words_to_send.push_back(32'h347F_FFE0);
		words_to_send.push_back(32'h5480_000F);
		words_to_send.push_back(32'h15FF_FFFF);
		words_to_send.push_back(32'h9600_0000);
		for (int k = int'(a64d_pkg::OP_UNKNOWN); k <= int'(a64d_pkg::OP_BL); k++)
			words_to_send.push_back(make_word(a64d_pkg::op_t'(k)));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < 4; ph++) begin
			src_idle_pct  <= src_pct[ph];
			snk_stall_pct <= snk_pct[ph];
			// Mostly encodings of known operations, some single-bit near misses and random words
			for (int n = 0; n < PHASE_WORDS; n++) begin
				mix      = $urandom_range(99);
				flip_bit = $urandom_range(31);
				w        = make_word(a64d_pkg::op_t'($urandom_range(int'(a64d_pkg::OP_BL))));
				if (mix < 15)
					w = $urandom;
				else if (mix < 30)
					w[flip_bit] = ~w[flip_bit];
				words_to_send.push_back(w);
			end
			while (words_to_send.size() != 0)
				@(posedge clk);
		end

		// Drain the pipeline, then wait out a quiet tail for stray words
		while (words_to_send.size() != 0 || instr_ch.valid || pending_decodes.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		foreach (op_seen[k])
			if (op_seen[k] != 0)
				ops_hit++;
		$display("Sent %0d instruction words over four idling phases, %0d decodes checked.",
			words_sent, decodes_checked);
		$display("Operation codes reached: %0d of %0d, field mismatches: %0d.",
			ops_hit, int'(a64d_pkg::OP_BL) + 1, mismatch_cnt);
		if (mismatch_cnt == 0 && pending_decodes.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
